// ===== hw/rtl/topt_pkg.sv =====
// Package for the 3-opt tour improver: sizes and register indexes.
// No dependencies.
`default_nettype none
package topt_pkg;
  localparam int unsigned MaxCitiesDef = 64;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned IdW  = 16;
  localparam int unsigned LenW = 31;
  localparam int unsigned CfgW = 7;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegSegStart = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSegEnd   = 1'b1;
endpackage
`default_nettype wire

// ===== hw/rtl/topt_edge.sv =====
// Edge length unit: floor(sqrt((dx^2+dy^2) << 16)), one root bit per cycle.
// Depends on topt_pkg.
`default_nettype none
module topt_edge import topt_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [CoordBits-1:0] ax_i,
  input  wire logic [CoordBits-1:0] ay_i,
  input  wire logic [CoordBits-1:0] bx_i,
  input  wire logic [CoordBits-1:0] by_i,
  output logic                      done_o,
  output logic [CoordBits+8:0]      len_o
);
  localparam int unsigned RadW = 2*CoordBits + 18;
  localparam int unsigned RootW = RadW/2;
  localparam int unsigned CntW = $clog2(RootW+1);

  logic [CoordBits-1:0] dx_q, dy_q;
  logic [2*CoordBits-1:0] sqx_q, sqy_q;
  logic [RadW-1:0] rad_q;
  logic [RootW-1:0] root_q;
  logic [RootW+1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic [2:0] ph_q;
  logic [RootW+1:0] trial, remsh;

  always_comb begin
    remsh = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
    trial = remsh - {root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= ph_q[2] && (cnt_q == CntW'(1));
      case (ph_q)
        3'd0: if (start_i) begin
          dx_q <= (ax_i > bx_i) ? ax_i - bx_i : bx_i - ax_i;
          dy_q <= (ay_i > by_i) ? ay_i - by_i : by_i - ay_i;
          ph_q <= 3'd1;
        end
        3'd1: begin
          sqx_q <= dx_q * dx_q;
          ph_q <= 3'd2;
        end
        3'd2: begin
          sqy_q <= dy_q * dy_q;
          ph_q <= 3'd3;
        end
        3'd3: begin
          rad_q <= {1'b0, {1'b0, sqx_q} + {1'b0, sqy_q}, 16'd0};
          root_q <= '0;
          rem_q <= '0;
          cnt_q <= CntW'(RootW);
          ph_q <= 3'd4;
        end
        default: begin
          if (!trial[RootW+1]) begin
            rem_q <= trial;
            root_q <= {root_q[RootW-2:0], 1'b1};
          end else begin
            rem_q <= remsh;
            root_q <= {root_q[RootW-2:0], 1'b0};
          end
          rad_q <= {rad_q[RadW-3:0], 2'b00};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            ph_q <= 3'd0;
          end
        end
      endcase
    end
  end
  assign len_o = root_q[CoordBits+8:0];
endmodule
`default_nettype wire

// ===== hw/rtl/three_opt_tour_improver.sv =====
// Three-opt tour improver: load cities one transfer per cycle; the transfer
// marked is_last starts an iterative 3-opt search held in on-chip memories.
// Channels: input (city_id, coord_x, coord_y, is_last) with in_valid_i /
// in_ready_o; output (out_city, tour_length, end_of_tour) with out_valid_o /
// out_ready_i; config writes (cfg_index_i, cfg_data_i) with cfg_valid_i /
// cfg_ready_o, index 0 = seg_start, index 1 = seg_end.
// Throughput: one city per cycle while loading. The last city blocks input
// for the search: each candidate move scores its removed and added edges (memory
// reads, then the shared root unit), plus for each kept move a candidate
// build over every position and a copy back of every position; passes
// repeat until none improves. Then one result per position; a stall holds
// the output register.
// Reset: loaded count zero, identity order is applied on each load, best
// length zero; no clearing pass. Memories need no reset.
`default_nettype none
module three_opt_tour_improver import topt_pkg::*; #(
  parameter int unsigned MaxCities = MaxCitiesDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [IdW-1:0]     city_id_i,
  input  wire logic [15:0]        coord_x_i,
  input  wire logic [15:0]        coord_y_i,
  input  wire logic               is_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [IdW-1:0]          out_city_o,
  output logic [LenW-1:0]         tour_length_o,
  output logic                    end_of_tour_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);
  localparam int unsigned AW = $clog2(MaxCities);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned EW = CoordBits + 9;
  localparam int unsigned SW = LenW + 2;

  typedef enum logic [3:0] {
    S_LOAD, S_TOT_A, S_TOT_B, S_TOT_E, S_MV_A, S_MV_B, S_MV_E,
    S_CP_R, S_CP_W, S_OUT_R, S_OUT_W
  } state_e;

  logic [CoordBits-1:0] x_mem [MaxCities];
  logic [CoordBits-1:0] y_mem [MaxCities];
  logic [IdW-1:0] id_mem [MaxCities];
  logic [AW-1:0] ord_mem [MaxCities];
  logic [AW-1:0] cand_mem [MaxCities];

  state_e st_q;
  logic [CfgW-1:0] seg_start_q, seg_end_q;
  logic [NW-1:0] n_q, end_q, i_q, j_q, k_q, p_q, w_q;
  logic [2:0] e_q;
  logic [2:0] sub_q;
  logic improved_q;
  logic [SW-1:0] cur_q, rem_q, add_q;
  logic [AW-1:0] ca_q, cb_q;
  logic [CoordBits-1:0] ax_q, ay_q, bx_q, by_q;
  logic [AW-1:0] ord_rd_q, cand_rd_q;
  logic [IdW-1:0] id_rd_q;
  logic eu_start_q, eu_done;
  logic [EW-1:0] eu_len;
  logic [NW-1:0] pa, pb, kn;

  assign kn = (k_q + 1'b1 == n_q) ? '0 : k_q + 1'b1;

  // endpoints for edge e of the current stage
  always_comb begin
    pa = '0; pb = '0;
    if (st_q inside {S_TOT_A, S_TOT_B, S_TOT_E}) begin
      pa = p_q;
      pb = (p_q + 1'b1 == n_q) ? '0 : p_q + 1'b1;
    end else begin
      case (e_q)
        3'd0: begin pa = i_q; pb = i_q + 1'b1; end
        3'd1: begin pa = j_q; pb = j_q + 1'b1; end
        3'd2: begin pa = k_q; pb = kn; end
        3'd3: begin pa = i_q; pb = j_q + 1'b1; end
        3'd4: begin pa = k_q; pb = i_q + 1'b1; end
        default: begin pa = j_q; pb = kn; end
      endcase
    end
  end

  // order map in the new tour: 0..i, j+1..k, i+1..j, k+1..n-1
  // read one position ahead of the candidate write
  logic [NW-1:0] ws, src;
  assign ws = (sub_q == 3'd0) ? w_q : w_q + 1'b1;
  always_comb begin
    if (ws <= i_q || ws > k_q) src = ws;
    else if (ws <= i_q + (k_q - j_q)) src = ws + (j_q - i_q);
    else src = ws - (k_q - j_q);
  end

  topt_edge #(.CoordBits(CoordBits)) u_edge (
    .clk_i, .rst_ni, .start_i(eu_start_q),
    .ax_i(ax_q), .ay_i(ay_q), .bx_i(bx_q), .by_i(by_q),
    .done_o(eu_done), .len_o(eu_len)
  );

  assign in_ready_o  = (st_q == S_LOAD);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i && n_q < NW'(MaxCities)) begin
      x_mem[n_q[AW-1:0]] <= coord_x_i[CoordBits-1:0];
      y_mem[n_q[AW-1:0]] <= coord_y_i[CoordBits-1:0];
      id_mem[n_q[AW-1:0]] <= city_id_i;
      ord_mem[n_q[AW-1:0]] <= n_q[AW-1:0];
    end else if (st_q == S_CP_W) begin
      ord_mem[w_q[AW-1:0]] <= cand_rd_q;
    end
    if (st_q == S_MV_E && w_q < n_q) cand_mem[w_q[AW-1:0]] <= ord_rd_q;
    ord_rd_q  <= ord_mem[(st_q == S_MV_E) ? src[AW-1:0] :
                         ((st_q == S_TOT_A || st_q == S_MV_A) && sub_q == 3'd0) ? pa[AW-1:0] :
                         (st_q == S_OUT_R) ? p_q[AW-1:0] : pb[AW-1:0]];
    cand_rd_q <= cand_mem[w_q[AW-1:0]];
    id_rd_q   <= id_mem[ord_rd_q];
    ax_q <= x_mem[ca_q]; ay_q <= y_mem[ca_q];
    bx_q <= x_mem[cb_q]; by_q <= y_mem[cb_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; seg_start_q <= '0; seg_end_q <= CfgW'(64);
      n_q <= '0; out_valid_o <= 1'b0; eu_start_q <= 1'b0;
      sub_q <= '0; e_q <= '0; improved_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; p_q <= '0; w_q <= '0; end_q <= '0;
      cur_q <= '0; rem_q <= '0; add_q <= '0; ca_q <= '0; cb_q <= '0;
      out_city_o <= '0; tour_length_o <= '0; end_of_tour_o <= 1'b0;
    end else begin
      eu_start_q <= (st_q == S_TOT_A || st_q == S_MV_A) && (sub_q == 3'd3);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegSegStart: seg_start_q <= cfg_data_i;
          default:     seg_end_q <= cfg_data_i;
        endcase
      end
      unique case (st_q)
        S_LOAD: if (in_valid_i) begin
          if (n_q < NW'(MaxCities)) n_q <= n_q + 1'b1;
          if (is_last_i) begin
            st_q <= S_TOT_A; p_q <= '0; cur_q <= '0; sub_q <= '0;
            end_q <= ({1'b0, seg_end_q} <
                      (CfgW+1)'(n_q) + (CfgW+1)'(n_q < NW'(MaxCities)))
                     ? NW'(seg_end_q) : n_q + NW'(n_q < NW'(MaxCities));
          end
        end
        // read a, then b; then registered coords; then launch root
        S_TOT_A, S_MV_A: begin
          if (sub_q == 3'd1) ca_q <= ord_rd_q;
          if (sub_q == 3'd2) cb_q <= ord_rd_q;
          if (sub_q == 3'd3) begin
            sub_q <= '0;
            st_q <= (st_q == S_TOT_A) ? S_TOT_E : S_MV_B;
          end else begin
            sub_q <= sub_q + 1'b1;
          end
        end
        S_TOT_E: if (eu_done) begin
          cur_q <= cur_q + SW'(eu_len);
          if (p_q + 1'b1 >= n_q) begin
            improved_q <= 1'b0; i_q <= NW'(seg_start_q);
            j_q <= NW'(seg_start_q) + 1'b1; k_q <= NW'(seg_start_q) + 2'd2;
            e_q <= '0; rem_q <= '0; add_q <= '0;
            st_q <= ((CfgW+1)'(seg_start_q) + (CfgW+1)'(2) < (CfgW+1)'(end_q))
                    ? S_MV_A : S_OUT_R;
            p_q <= '0;
          end else begin
            p_q <= p_q + 1'b1; st_q <= S_TOT_A;
          end
        end
        S_MV_B: if (eu_done) begin
          if (e_q < 3'd3) rem_q <= rem_q + SW'(eu_len);
          else if (e_q != 3'd5) add_q <= add_q + SW'(eu_len);
          if (e_q == 3'd5) begin
            e_q <= '0;
            if (add_q + SW'(eu_len) < rem_q) begin
              cur_q <= cur_q - rem_q + add_q + SW'(eu_len);
              improved_q <= 1'b1; w_q <= '0; sub_q <= '0; st_q <= S_MV_E;
            end else begin
              rem_q <= '0; add_q <= '0;
              // advance k, j, i
              if (k_q + 1'b1 < end_q) begin k_q <= k_q + 1'b1; st_q <= S_MV_A; end
              else if (j_q + 2'd2 < end_q) begin
                j_q <= j_q + 1'b1; k_q <= j_q + 2'd2; st_q <= S_MV_A;
              end else if (i_q + 2'd3 < end_q) begin
                i_q <= i_q + 1'b1; j_q <= i_q + 2'd2; k_q <= i_q + 2'd3;
                st_q <= S_MV_A;
              end else if (improved_q) begin
                improved_q <= 1'b0; i_q <= NW'(seg_start_q);
                j_q <= NW'(seg_start_q) + 1'b1; k_q <= NW'(seg_start_q) + 2'd2;
                st_q <= S_MV_A;
              end else begin
                p_q <= '0; st_q <= S_OUT_R;
              end
            end
          end else begin
            e_q <= e_q + 1'b1; st_q <= S_MV_A;
          end
        end
        // build candidate: read source, write it in the next cycle
        S_MV_E: begin
          if (sub_q == 3'd0) sub_q <= 3'd1;
          else if (w_q + 1'b1 >= n_q) begin
            w_q <= '0; sub_q <= '0; st_q <= S_CP_R;
          end else begin
            w_q <= w_q + 1'b1;
          end
        end
        S_CP_R: st_q <= S_CP_W;
        S_CP_W: begin
          if (w_q + 1'b1 >= n_q) begin
            w_q <= '0; rem_q <= '0; add_q <= '0; st_q <= S_MV_A;
            if (k_q + 1'b1 < end_q) k_q <= k_q + 1'b1;
            else if (j_q + 2'd2 < end_q) begin
              j_q <= j_q + 1'b1; k_q <= j_q + 2'd2;
            end else if (i_q + 2'd3 < end_q) begin
              i_q <= i_q + 1'b1; j_q <= i_q + 2'd2; k_q <= i_q + 2'd3;
            end else begin
              improved_q <= 1'b0; i_q <= NW'(seg_start_q);
              j_q <= NW'(seg_start_q) + 1'b1; k_q <= NW'(seg_start_q) + 2'd2;
            end
          end else begin
            w_q <= w_q + 1'b1; st_q <= S_CP_R;
          end
        end
        S_OUT_R: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b0;
            if (p_q >= n_q) begin n_q <= '0; st_q <= S_LOAD; end
            else begin sub_q <= '0; st_q <= S_OUT_W; end
          end
        end
        default: begin
          sub_q <= sub_q + 1'b1;
          if (sub_q == 3'd1) begin
            out_city_o <= id_rd_q; tour_length_o <= cur_q[LenW-1:0];
            end_of_tour_o <= (p_q + 1'b1 == n_q); out_valid_o <= 1'b1;
            p_q <= p_q + 1'b1; st_q <= S_OUT_R;
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("out/in overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_city_o)) else $error("held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MaxCities)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> st_q == S_OUT_R) else $error("valid outside output");
endmodule
`default_nettype wire
